>>> rtl/joystick_angle_with_dead_zone_unit_macros.svh
// assertion helpers for the joystick angle unit
`ifndef JOYSTICK_ANGLE_WITH_DEAD_ZONE_UNIT_MACROS_SVH
`define JOYSTICK_ANGLE_WITH_DEAD_ZONE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define JADZ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("joystick angle unit: same-cycle check failed");
// next-cycle implication
`define JADZ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("joystick angle unit: next-cycle check failed");
`else
`define JADZ_ASSERT_IMP(label, clk, rst, ante, cons)
`define JADZ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/jadz_pkg.sv
package jadz_pkg;

  localparam int unsigned STEPS_PER_TURN_DEF = 2047;
  localparam int unsigned CORDIC_STAGES_DEF  = 16;
  localparam int unsigned ATAN_LEN           = 24;
  localparam int unsigned ATAN_IDX_W         = 5;
  localparam int unsigned ATAN_W             = 22;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned ANGLE_W  = 17;
  localparam int unsigned DIFF_W   = 11;
  localparam int unsigned MAG_W    = 10;
  localparam int unsigned SQ_W     = 20;
  localparam int unsigned CX_W     = 26;
  localparam int unsigned Z_W      = 25;
  localparam int unsigned ZC_W     = 23;
  localparam int unsigned AQ_W     = 15;
  localparam int unsigned FRAC_SH  = 12;

  // position to degrees: numerator, reciprocal and quotient widths
  localparam int unsigned STEPS_W     = 16;
  localparam int unsigned NUM_W       = 28;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned QUOT_W      = 25;

  localparam logic [ANGLE_W-1:0] DEG90_Q8    = 17'd23040;
  localparam logic [ANGLE_W-1:0] DEG180_Q8   = 17'd46080;
  localparam logic [ANGLE_W-1:0] DEG360_Q8   = 17'd92160;
  localparam logic [ANGLE_W-1:0] SENTINEL_Q8 = 17'd102400;
  localparam logic [ZC_W-1:0]    DEG90_Q16   = 23'd5898240;

  localparam logic [SAMPLE_W-1:0] CENTRE_X_RST    = 10'd477;
  localparam logic [SAMPLE_W-1:0] CENTRE_Y_RST    = 10'd471;
  localparam logic [SAMPLE_W-1:0] DEAD_RADIUS_RST = 10'd50;

  typedef enum logic [1:0] {
    CFG_CENTRE_X    = 2'd0,
    CFG_CENTRE_Y    = 2'd1,
    CFG_DEAD_RADIUS = 2'd2,
    CFG_DEAD_MODE   = 2'd3
  } cfg_idx_t;

  // flags that ride along with the cordic datapath
  typedef struct packed {
    logic               dx_neg;
    logic               dy_neg;
    logic               ax_zero;
    logic               ay_zero;
    logic               dead;
    logic               mode;
    logic [ANGLE_W-1:0] pos_angle;
  } side_t;

  // atan(2^-i) in degrees * 2^16, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/joystick_angle_with_dead_zone_unit.sv
// Joystick angle unit: takes one (x_sample, y_sample, motor_position) transaction per cycle
// unless stalled and returns one angle_q8 per transaction, in order. The angle comes from the
// pipelined CORDIC in vectoring mode with one micro-rotation per stage;
// the dead-zone test and the step-to-degree conversion run in parallel stages beside it.
// Throughput is one transaction per cycle unless stalled. A skid register behind the last
// stage takes one result when the output stalls; the whole pipeline then holds until it drains.
// Configuration is written through cfg_* (always ready) and must only change while idle.
`include "joystick_angle_with_dead_zone_unit_macros.svh"

module joystick_angle_with_dead_zone_unit #(
  parameter int unsigned STEPS_PER_TURN = jadz_pkg::STEPS_PER_TURN_DEF,
  parameter int unsigned CORDIC_STAGES  = jadz_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [jadz_pkg::SAMPLE_W-1:0]    x_sample,
  input  logic [jadz_pkg::SAMPLE_W-1:0]    y_sample,
  input  logic [jadz_pkg::POS_W-1:0]       motor_position,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [jadz_pkg::ANGLE_W-1:0]     angle_q8,
  output logic                             in_dead_zone,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [jadz_pkg::SAMPLE_W-1:0]    cfg_data
);

  localparam int unsigned NITER = (CORDIC_STAGES > jadz_pkg::ATAN_LEN) ?
                                  jadz_pkg::ATAN_LEN : CORDIC_STAGES;
  localparam int unsigned NS    = NITER + 4;
  localparam int unsigned PROD_W = jadz_pkg::NUM_W + jadz_pkg::RECIP_W;
  localparam int unsigned MT_W   = jadz_pkg::QUOT_W + jadz_pkg::STEPS_W;

  localparam logic [jadz_pkg::STEPS_W-1:0] STEPS =
    jadz_pkg::STEPS_W'(STEPS_PER_TURN);
  localparam logic [jadz_pkg::NUM_W-1:0] HALF_STEPS =
    jadz_pkg::NUM_W'(STEPS_PER_TURN / 2);
  localparam logic [jadz_pkg::RECIP_W-1:0] RECIP =
    jadz_pkg::RECIP_W'((64'd1 << jadz_pkg::RECIP_SHIFT) / 64'(STEPS_PER_TURN));

  // configuration
  logic [jadz_pkg::SAMPLE_W-1:0] centre_x;
  logic [jadz_pkg::SAMPLE_W-1:0] centre_y;
  logic [jadz_pkg::SAMPLE_W-1:0] dead_radius;
  logic                          dead_zone_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x       <= jadz_pkg::CENTRE_X_RST;
      centre_y       <= jadz_pkg::CENTRE_Y_RST;
      dead_radius    <= jadz_pkg::DEAD_RADIUS_RST;
      dead_zone_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (jadz_pkg::cfg_idx_t'(cfg_index))
        jadz_pkg::CFG_CENTRE_X:    centre_x       <= cfg_data;
        jadz_pkg::CFG_CENTRE_Y:    centre_y       <= cfg_data;
        jadz_pkg::CFG_DEAD_RADIUS: dead_radius    <= cfg_data;
        jadz_pkg::CFG_DEAD_MODE:   dead_zone_mode <= cfg_data[0];
      endcase
    end
  end

  // pipeline control
  logic [NS-1:0] vld;
  logic          en;
  logic          sk_full;

  assign en       = !sk_full;
  assign in_stall = sk_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // stage 0: centre offsets, position numerator
  logic signed [jadz_pkg::DIFF_W-1:0] s0_dx;
  logic signed [jadz_pkg::DIFF_W-1:0] s0_dy;
  logic [jadz_pkg::NUM_W-1:0]         s0_num;
  logic [jadz_pkg::SAMPLE_W-1:0]      s0_radius;
  logic                               s0_mode;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_dx     <= $signed({1'b0, x_sample}) - $signed({1'b0, centre_x});
      s0_dy     <= $signed({1'b0, y_sample}) - $signed({1'b0, centre_y});
      s0_num    <= jadz_pkg::NUM_W'(motor_position) * jadz_pkg::NUM_W'(jadz_pkg::DEG360_Q8)
                   + HALF_STEPS;
      s0_radius <= dead_radius;
      s0_mode   <= dead_zone_mode;
    end
  end

  // stage 1: squares, magnitudes, reciprocal product
  logic signed [2*jadz_pkg::DIFF_W-1:0] dx_sq;
  logic signed [2*jadz_pkg::DIFF_W-1:0] dy_sq;
  logic signed [jadz_pkg::DIFF_W-1:0]   dx_abs;
  logic signed [jadz_pkg::DIFF_W-1:0]   dy_abs;

  assign dx_sq  = s0_dx * s0_dx;
  assign dy_sq  = s0_dy * s0_dy;
  assign dx_abs = s0_dx[jadz_pkg::DIFF_W-1] ? -s0_dx : s0_dx;
  assign dy_abs = s0_dy[jadz_pkg::DIFF_W-1] ? -s0_dy : s0_dy;

  logic [jadz_pkg::SQ_W-1:0]  s1_dx2;
  logic [jadz_pkg::SQ_W-1:0]  s1_dy2;
  logic [jadz_pkg::SQ_W-1:0]  s1_r2;
  logic [PROD_W-1:0]          s1_prod;
  logic [jadz_pkg::NUM_W-1:0] s1_num;

  logic signed [jadz_pkg::CX_W-1:0] cx [NITER+1];
  logic signed [jadz_pkg::CX_W-1:0] cy [NITER+1];
  logic signed [jadz_pkg::Z_W-1:0]  cz [NITER+1];
  jadz_pkg::side_t                  sd [NITER+1];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx2  <= jadz_pkg::SQ_W'(dx_sq);
      s1_dy2  <= jadz_pkg::SQ_W'(dy_sq);
      s1_r2   <= jadz_pkg::SQ_W'(s0_radius) * jadz_pkg::SQ_W'(s0_radius);
      s1_prod <= PROD_W'(s0_num) * PROD_W'(RECIP);
      s1_num  <= s0_num;
      cx[0]   <= jadz_pkg::CX_W'({dx_abs[jadz_pkg::MAG_W-1:0], {jadz_pkg::FRAC_SH{1'b0}}});
      cy[0]   <= jadz_pkg::CX_W'({dy_abs[jadz_pkg::MAG_W-1:0], {jadz_pkg::FRAC_SH{1'b0}}});
      cz[0]   <= '0;
      sd[0].dx_neg    <= s0_dx[jadz_pkg::DIFF_W-1];
      sd[0].dy_neg    <= s0_dy[jadz_pkg::DIFF_W-1];
      sd[0].ax_zero   <= (s0_dx == '0);
      sd[0].ay_zero   <= (s0_dy == '0);
      sd[0].dead      <= 1'b0;
      sd[0].mode      <= s0_mode;
      sd[0].pos_angle <= '0;
    end
  end

  // side path for the position angle: quotient estimate, back-multiply, correction
  logic [jadz_pkg::QUOT_W-1:0] a2_q0;
  logic [jadz_pkg::NUM_W-1:0]  a2_num;
  logic [MT_W-1:0]             q0_times_s;
  logic [jadz_pkg::QUOT_W-1:0] a3_q0;
  logic [jadz_pkg::NUM_W-1:0]  a3_num;
  logic [jadz_pkg::NUM_W-1:0]  a3_t;
  logic [jadz_pkg::NUM_W-1:0]  pos_rem;
  logic [jadz_pkg::QUOT_W-1:0] pos_q;
  logic [jadz_pkg::ANGLE_W-1:0] pos_angle;

  assign q0_times_s = MT_W'(a2_q0) * MT_W'(STEPS);
  assign pos_rem    = a3_num - a3_t;
  // estimate is low by at most one
  assign pos_q      = (pos_rem >= jadz_pkg::NUM_W'(STEPS)) ? a3_q0 + 1'b1 : a3_q0;
  assign pos_angle  = (pos_q > jadz_pkg::QUOT_W'(jadz_pkg::DEG360_Q8)) ?
                      jadz_pkg::DEG360_Q8 : pos_q[jadz_pkg::ANGLE_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      a2_q0  <= s1_prod[PROD_W-1:jadz_pkg::RECIP_SHIFT];
      a2_num <= s1_num;
      a3_q0  <= a2_q0;
      a3_num <= a2_num;
      a3_t   <= q0_times_s[jadz_pkg::NUM_W-1:0];
    end
  end

  // cordic micro-rotations, one per stage
  logic [jadz_pkg::SQ_W:0] d2_sum;
  assign d2_sum = {1'b0, s1_dx2} + {1'b0, s1_dy2};

  for (genvar i = 0; i < NITER; i++) begin : g_cordic
    logic signed [jadz_pkg::CX_W-1:0] xs;
    logic signed [jadz_pkg::CX_W-1:0] ys;
    logic signed [jadz_pkg::Z_W-1:0]  at;
    logic                             y_pos;
    jadz_pkg::side_t                  sd_in;

    assign xs    = cx[i] >>> i;
    assign ys    = cy[i] >>> i;
    assign at    = $signed(jadz_pkg::Z_W'(jadz_pkg::atan_q16(jadz_pkg::ATAN_IDX_W'(i))));
    assign y_pos = !cy[i][jadz_pkg::CX_W-1] && (cy[i] != '0);

    // dead-zone flag and position angle join the side data where they are ready
    always_comb begin
      sd_in = sd[i];
      if (i == 0) begin
        sd_in.dead = (d2_sum < {1'b0, s1_r2});
      end
      if (i == 2) begin
        sd_in.pos_angle = pos_angle;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_pos) begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + at;
        end else begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - at;
        end
        sd[i+1] <= sd_in;
      end
    end
  end

  // clamp to 0..90, round to q8, exact axes
  logic [jadz_pkg::ZC_W-1:0] z_clamp;
  logic [jadz_pkg::ZC_W:0]   z_round;
  logic [jadz_pkg::AQ_W-1:0] r_a;
  jadz_pkg::side_t           r_sd;

  always_comb begin
    priority if (cz[NITER][jadz_pkg::Z_W-1]) begin
      z_clamp = '0;
    end else if (cz[NITER] > $signed(jadz_pkg::Z_W'(jadz_pkg::DEG90_Q16))) begin
      z_clamp = jadz_pkg::DEG90_Q16;
    end else begin
      z_clamp = cz[NITER][jadz_pkg::ZC_W-1:0];
    end
  end

  assign z_round = ({1'b0, z_clamp} + (jadz_pkg::ZC_W+1)'(128)) >> 8;

  always_ff @(posedge clk) begin
    if (en) begin
      r_sd <= sd[NITER];
      priority if (sd[NITER].ay_zero) begin
        r_a <= '0;
      end else if (sd[NITER].ax_zero) begin
        r_a <= jadz_pkg::AQ_W'(jadz_pkg::DEG90_Q8);
      end else begin
        r_a <= z_round[jadz_pkg::AQ_W-1:0];
      end
    end
  end

  // quadrant mapping and final select
  logic [jadz_pkg::ANGLE_W-1:0] a_ext;
  logic [jadz_pkg::ANGLE_W-1:0] quad;
  logic [jadz_pkg::ANGLE_W-1:0] o_angle;
  logic                         o_dead;

  assign a_ext = jadz_pkg::ANGLE_W'(r_a);

  always_comb begin
    priority if (!r_sd.dx_neg && !r_sd.dy_neg) begin
      quad = a_ext;
    end else if (r_sd.dx_neg && !r_sd.dy_neg) begin
      quad = jadz_pkg::DEG180_Q8 - a_ext;
    end else if (r_sd.dx_neg) begin
      quad = jadz_pkg::DEG180_Q8 + a_ext;
    end else begin
      quad = jadz_pkg::DEG360_Q8 - a_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_dead <= r_sd.dead;
      if (r_sd.dead) begin
        o_angle <= r_sd.mode ? jadz_pkg::SENTINEL_Q8 : r_sd.pos_angle;
      end else if (quad >= jadz_pkg::DEG360_Q8) begin
        o_angle <= '0;
      end else begin
        o_angle <= quad;
      end
    end
  end

  // skid register behind the last stage
  logic [jadz_pkg::ANGLE_W-1:0] sk_angle;
  logic                         sk_dead;

  always_ff @(posedge clk) begin
    if (rst) begin
      sk_full <= 1'b0;
    end else if (sk_full) begin
      if (!out_stall) begin
        sk_full <= 1'b0;
      end
    end else if (vld[NS-1] && out_stall) begin
      sk_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_full) begin
      sk_angle <= o_angle;
      sk_dead  <= o_dead;
    end
  end

  assign out_valid    = sk_full || vld[NS-1];
  assign angle_q8     = sk_full ? sk_angle : o_angle;
  assign in_dead_zone = sk_full ? sk_dead : o_dead;

  `JADZ_ASSERT_NXT(a_accept_enters, clk, rst, in_valid && !in_stall, vld[0])
  `JADZ_ASSERT_NXT(a_skid_drains, clk, rst, sk_full && !out_stall, !sk_full)
  `JADZ_ASSERT_IMP(a_live_angle_range, clk, rst, out_valid && !in_dead_zone,
                   angle_q8 < jadz_pkg::DEG360_Q8)
  `JADZ_ASSERT_IMP(a_dead_angle_range, clk, rst, out_valid && in_dead_zone,
                   angle_q8 <= jadz_pkg::DEG360_Q8 || angle_q8 == jadz_pkg::SENTINEL_Q8)

endmodule

>>> tb/joystick_angle_with_dead_zone_unit_test.sv
`timescale 1ns / 1ps

module joystick_angle_with_dead_zone_unit_test;

  localparam int PIPE_LATENCY = int'(jadz_pkg::CORDIC_STAGES_DEF) + 4;
  localparam int ROT_STAGES   = (jadz_pkg::CORDIC_STAGES_DEF > 24) ? 24 :
                                int'(jadz_pkg::CORDIC_STAGES_DEF);
  localparam longint TURN_STEPS = longint'(jadz_pkg::STEPS_PER_TURN_DEF);
  localparam int SAMPLE_MAX   = (1 << jadz_pkg::SAMPLE_W) - 1;
  localparam int POS_MAX      = (1 << jadz_pkg::POS_W) - 1;
  localparam longint DEG90_L    = longint'(jadz_pkg::DEG90_Q8);
  localparam longint DEG180_L   = longint'(jadz_pkg::DEG180_Q8);
  localparam longint DEG360_L   = longint'(jadz_pkg::DEG360_Q8);
  localparam longint DEG90_Q16_L = longint'(jadz_pkg::DEG90_Q16);

  typedef struct {
    logic [jadz_pkg::ANGLE_W-1:0] angle;
    logic                         dead;
  } angle_result_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [jadz_pkg::SAMPLE_W-1:0] x_sample;
  logic [jadz_pkg::SAMPLE_W-1:0] y_sample;
  logic [jadz_pkg::POS_W-1:0]    motor_position;
  logic                          out_valid;
  logic                          out_stall;
  logic [jadz_pkg::ANGLE_W-1:0]  angle_q8;
  logic                          in_dead_zone;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [1:0]                    cfg_index;
  logic [jadz_pkg::SAMPLE_W-1:0] cfg_data;

  // shadow copy of the register file
  logic [jadz_pkg::SAMPLE_W-1:0] centre_x_cfg;
  logic [jadz_pkg::SAMPLE_W-1:0] centre_y_cfg;
  logic [jadz_pkg::SAMPLE_W-1:0] radius_cfg;
  logic                          zone_mode_cfg;

  // atan(2^-i) in degrees * 2^16
  longint rot_angle_q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  angle_result_t expected_angles[$];

  int mismatches;
  int samples_sent;
  int results_checked;
  int dead_zone_hits;
  int sentinel_hits;
  int settings_used;
  int backlog_hold;
  bit rx_quiet;
  bit tx_quiet;

  joystick_angle_with_dead_zone_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .x_sample       (x_sample),
    .y_sample       (y_sample),
    .motor_position (motor_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .angle_q8       (angle_q8),
    .in_dead_zone   (in_dead_zone),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #9_600_000;
    $display("joystick_angle_with_dead_zone_unit verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic angle_result_t predict_angle(input logic [jadz_pkg::SAMPLE_W-1:0] xs,
                                                  input logic [jadz_pkg::SAMPLE_W-1:0] ys,
                                                  input logic [jadz_pkg::POS_W-1:0] pos);
    angle_result_t r;
    longint cx, cy, rad, dx, dy, ax, ay, d2, a, res, xr, yr, xsh, ysh, z, p;
    int k;
    cx = longint'(centre_x_cfg);
    cy = longint'(centre_y_cfg);
    rad = longint'(radius_cfg);
    dx = longint'(xs);
    dy = longint'(ys);
    dx = dx - cx;
    dy = dy - cy;
    d2 = dx * dx + dy * dy;
    if (d2 < rad * rad) begin
      r.dead = 1'b1;
      if (zone_mode_cfg) begin
        r.angle = jadz_pkg::SENTINEL_Q8;
      end else begin
        p = longint'(pos);
        p = (p * DEG360_L + TURN_STEPS / 2) / TURN_STEPS;
        if (p > DEG360_L) p = DEG360_L;
        r.angle = p[jadz_pkg::ANGLE_W-1:0];
      end
      return r;
    end
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ay == 0) begin
      a = 0;
    end else if (ax == 0) begin
      a = DEG90_L;
    end else begin
      xr = ax * 4096;
      yr = ay * 4096;
      z = 0;
      for (k = 0; k < ROT_STAGES; k++) begin
        xsh = xr >>> k;
        ysh = yr >>> k;
        if (yr > 0) begin
          xr = xr + ysh;
          yr = yr - xsh;
          z = z + rot_angle_q16[k];
        end else begin
          xr = xr - ysh;
          yr = yr + xsh;
          z = z - rot_angle_q16[k];
        end
      end
      if (z < 0) z = 0;
      if (z > DEG90_Q16_L) z = DEG90_Q16_L;
      a = (z + 128) >>> 8;
    end
    if (dx >= 0 && dy >= 0) res = a;
    else if (dx < 0 && dy >= 0) res = DEG180_L - a;
    else if (dx < 0) res = DEG180_L + a;
    else res = DEG360_L - a;
    if (res >= DEG360_L) res = 0;
    r.angle = res[jadz_pkg::ANGLE_W-1:0];
    r.dead = 1'b0;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 55) return 0;
    if (roll < 85) return int'($urandom_range(1, 3));
    if (roll < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 50));
  endfunction

  function automatic logic [jadz_pkg::SAMPLE_W-1:0] clamp_sample(input longint v);
    if (v < 0) return '0;
    if (v > SAMPLE_MAX) return jadz_pkg::SAMPLE_W'(SAMPLE_MAX);
    return v[jadz_pkg::SAMPLE_W-1:0];
  endfunction

  // called right after a rising edge; returns at the edge that accepts the transaction
  task automatic send_sample(input logic [jadz_pkg::SAMPLE_W-1:0] xs,
                             input logic [jadz_pkg::SAMPLE_W-1:0] ys,
                             input logic [jadz_pkg::POS_W-1:0] pos);
    angle_result_t want;
    logic stalled;
    in_valid <= 1'b1;
    x_sample <= xs;
    y_sample <= ys;
    motor_position <= pos;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    want = predict_angle(xs, ys, pos);
    expected_angles.push_back(want);
    samples_sent++;
    if (want.dead) dead_zone_hits++;
    if (want.dead && zone_mode_cfg) sentinel_hits++;
  endtask

  task automatic sender_gap();
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_with_gap(input logic [jadz_pkg::SAMPLE_W-1:0] xs,
                               input logic [jadz_pkg::SAMPLE_W-1:0] ys,
                               input logic [jadz_pkg::POS_W-1:0] pos);
    send_sample(xs, ys, pos);
    sender_gap();
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_angles.size() > 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_register(input jadz_pkg::cfg_idx_t idx,
                                input logic [jadz_pkg::SAMPLE_W-1:0] data);
    logic ready_seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
    case (idx)
      jadz_pkg::CFG_CENTRE_X:    centre_x_cfg = data;
      jadz_pkg::CFG_CENTRE_Y:    centre_y_cfg = data;
      jadz_pkg::CFG_DEAD_RADIUS: radius_cfg = data;
      jadz_pkg::CFG_DEAD_MODE:   zone_mode_cfg = data[0];
      default: ;
    endcase
  endtask

  // only while idle; upper bits of the mode write are junk on purpose
  task automatic program_settings(input logic [jadz_pkg::SAMPLE_W-1:0] cx,
                                  input logic [jadz_pkg::SAMPLE_W-1:0] cy,
                                  input logic [jadz_pkg::SAMPLE_W-1:0] rad, input logic mode);
    logic [jadz_pkg::SAMPLE_W-1:0] mode_word;
    mode_word = jadz_pkg::SAMPLE_W'($urandom);
    mode_word[0] = mode;
    write_register(jadz_pkg::CFG_CENTRE_X, cx);
    write_register(jadz_pkg::CFG_CENTRE_Y, cy);
    write_register(jadz_pkg::CFG_DEAD_RADIUS, rad);
    write_register(jadz_pkg::CFG_DEAD_MODE, mode_word);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic next_sample(output logic [jadz_pkg::SAMPLE_W-1:0] xs,
                             output logic [jadz_pkg::SAMPLE_W-1:0] ys,
                             output logic [jadz_pkg::POS_W-1:0] pos);
    int kind;
    longint dx, dy, span, rad, m;
    kind = int'($urandom_range(0, 99));
    rad = longint'(radius_cfg);
    m = longint'($urandom_range(0, 2 * SAMPLE_MAX));
    m = m - SAMPLE_MAX;
    if (kind < 30) begin
      dx = longint'($urandom_range(0, SAMPLE_MAX));
      dy = longint'($urandom_range(0, SAMPLE_MAX));
      dx = dx - longint'(centre_x_cfg);
      dy = dy - longint'(centre_y_cfg);
    end else if (kind < 55) begin
      span = rad + 3;
      dx = longint'($urandom_range(0, 32'(2 * span)));
      dy = longint'($urandom_range(0, 32'(2 * span)));
      dx = dx - span;
      dy = dy - span;
    end else if (kind < 70) begin
      // offset lies on one of the axes
      dx = ($urandom_range(0, 1) != 0) ? m : 0;
      dy = (dx == 0) ? m : 0;
    end else if (kind < 82) begin
      dx = m;
      dy = ($urandom_range(0, 1) != 0) ? m : -m;
    end else begin
      // right at the edge of the dead-zone circle
      dx = longint'($urandom_range(0, 32'(rad)));
      dy = longint'($rtoi($sqrt(real'(rad * rad - dx * dx))));
      dy = dy + longint'($urandom_range(0, 1));
      if ($urandom_range(0, 1) != 0) dx = -dx;
      if ($urandom_range(0, 1) != 0) dy = -dy;
    end
    xs = clamp_sample(dx + longint'(centre_x_cfg));
    ys = clamp_sample(dy + longint'(centre_y_cfg));
    kind = int'($urandom_range(0, 99));
    if (kind < 85) pos = jadz_pkg::POS_W'($urandom_range(0, POS_MAX));
    else if (kind < 88) pos = '0;
    else if (kind < 91) pos = 11'd1;
    else if (kind < 94) pos = 11'd1023;
    else if (kind < 97) pos = jadz_pkg::POS_W'(POS_MAX - 1);
    else pos = jadz_pkg::POS_W'(POS_MAX);
  endtask

  // receiver: random stalls, quiet stretches, and one long hold-off on request
  initial begin : result_sink
    int stall_run;
    int free_run;
    int roll;
    stall_run = 0;
    free_run = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (backlog_hold > 0) begin
        backlog_hold--;
        out_stall <= 1'b1;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
      end else if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else if (free_run > 0) begin
        free_run--;
        out_stall <= 1'b0;
      end else begin
        roll = int'($urandom_range(0, 99));
        free_run = (roll < 85) ? int'($urandom_range(0, 6)) : int'($urandom_range(10, 40));
        roll = int'($urandom_range(0, 99));
        if (roll < 70) stall_run = int'($urandom_range(1, 2));
        else if (roll < 95) stall_run = int'($urandom_range(3, 8));
        else stall_run = int'($urandom_range(15, 40));
        out_stall <= 1'b0;
      end
    end
  end

  // payload is stable from the falling edge until the edge that takes the transaction
  always @(negedge clk) begin : angle_checker
    angle_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_angles.size() == 0) begin
        report_mismatch("result with nothing pending, angle_q8", longint'(angle_q8), -1);
      end else begin
        want = expected_angles.pop_front();
        results_checked++;
        if (angle_q8 !== want.angle) begin
          report_mismatch("angle_q8", longint'(angle_q8), longint'(want.angle));
        end
        if (in_dead_zone !== want.dead) begin
          report_mismatch("in_dead_zone", longint'(in_dead_zone), longint'(want.dead));
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_with_gap(10'd577, 10'd471, 11'd5);
    send_with_gap(10'd377, 10'd471, 11'd6);
    send_with_gap(10'd477, 10'd571, 11'd7);
    send_with_gap(10'd477, 10'd371, 11'd8);
    send_with_gap(10'd477, 10'd471, 11'd0);
    send_with_gap(10'd477, 10'd471, 11'd2047);
    send_with_gap(10'd478, 10'd471, 11'd1023);
    send_with_gap(10'd477, 10'd472, 11'd1);
    send_with_gap(10'd507, 10'd511, 11'd2046);
    send_with_gap(10'd507, 10'd510, 11'd700);
    send_with_gap(10'd0, 10'd0, 11'd0);
    send_with_gap(10'd1023, 10'd1023, 11'd2047);
    send_with_gap(10'd0, 10'd1023, 11'd1024);
    send_with_gap(10'd1023, 10'd0, 11'd512);
    // just below a full turn and just above zero
    send_with_gap(10'd1023, 10'd470, 11'd3);
    send_with_gap(10'd1023, 10'd472, 11'd4);
    wait_drain();
  endtask

  task automatic test_zero_radius_and_sentinel();
    program_settings(10'd0, 10'd1023, 10'd0, 1'b1);
    send_with_gap(10'd0, 10'd1023, 11'd100);
    send_with_gap(10'd1023, 10'd0, 11'd200);
    send_with_gap(10'd1, 10'd1023, 11'd300);
    wait_drain();
    program_settings(10'd1023, 10'd0, 10'd1023, 1'b1);
    send_with_gap(10'd1023, 10'd0, 11'd0);
    send_with_gap(10'd0, 10'd1023, 11'd2047);
    send_with_gap(10'd1000, 10'd20, 11'd1500);
    wait_drain();
  endtask

  task automatic test_backpressure();
    logic [jadz_pkg::SAMPLE_W-1:0] xs, ys;
    logic [jadz_pkg::POS_W-1:0] pos;
    int n;
    program_settings(jadz_pkg::CENTRE_X_RST, jadz_pkg::CENTRE_Y_RST, jadz_pkg::DEAD_RADIUS_RST,
                     1'b0);
    @(negedge clk);
    backlog_hold = 70;
    tx_quiet = 1'b1;
    @(posedge clk);
    for (n = 0; n < 64; n++) begin
      next_sample(xs, ys, pos);
      send_with_gap(xs, ys, pos);
    end
    tx_quiet = 1'b0;
    wait_drain();
  endtask

  task automatic test_random_sweep();
    logic [jadz_pkg::SAMPLE_W-1:0] xs, ys, cx, cy, rad;
    logic [jadz_pkg::POS_W-1:0] pos;
    logic mode;
    int phase, n;
    for (phase = 0; phase < 8; phase++) begin
      cx = jadz_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      cy = jadz_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      rad = ($urandom_range(0, 3) == 0) ? jadz_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX)) :
                                          jadz_pkg::SAMPLE_W'($urandom_range(0, 120));
      mode = ($urandom_range(0, 1) != 0);
      case (phase)
        0: program_settings(10'd0, 10'd0, 10'd0, 1'b0);
        1: program_settings(10'd1023, 10'd1023, 10'd1023, 1'b1);
        2: program_settings(10'd512, 10'd512, 10'd1023, 1'b0);
        3: program_settings(10'd512, 10'd512, 10'd0, 1'b1);
        default: program_settings(cx, cy, rad, mode);
      endcase
      // one phase runs with neither side idling
      @(negedge clk);
      rx_quiet = (phase == 5);
      tx_quiet = (phase == 5);
      @(posedge clk);
      for (n = 0; n < 125; n++) begin
        next_sample(xs, ys, pos);
        send_with_gap(xs, ys, pos);
      end
      wait_drain();
      @(negedge clk);
      rx_quiet = 1'b0;
      tx_quiet = 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    centre_x_cfg = jadz_pkg::CENTRE_X_RST;
    centre_y_cfg = jadz_pkg::CENTRE_Y_RST;
    radius_cfg = jadz_pkg::DEAD_RADIUS_RST;
    zone_mode_cfg = 1'b0;
    mismatches = 0;
    samples_sent = 0;
    results_checked = 0;
    dead_zone_hits = 0;
    sentinel_hits = 0;
    settings_used = 1;
    backlog_hold = 0;
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    x_sample <= '0;
    y_sample <= '0;
    motor_position <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= jadz_pkg::CFG_CENTRE_X;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_zero_radius_and_sentinel();
    test_backpressure();
    test_random_sweep();

    repeat (8) @(posedge clk);
    $display("covered %0d samples over %0d register settings, %0d results checked",
             samples_sent, settings_used, results_checked);
    $display("dead-zone samples: %0d, of them %0d with the sentinel", dead_zone_hits,
             sentinel_hits);
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("joystick_angle_with_dead_zone_unit verification clean");
    end else begin
      $display("joystick_angle_with_dead_zone_unit verification failed");
    end
    $finish;
  end

endmodule
